// ===== hdl/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the RTL.
// Expects clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pls_pkg.sv =====
// pls_pkg: widths, request and status codes, controller/datapath bundles
// for the positional list store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int REQ_W  = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;

  localparam logic [REQ_W-1:0] REQ_READ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic idx_pos;
    logic idx_last;
    logic idx_inc;
    logic idx_dec;
    logic rd;
    logic rd_next;
    logic cap;
    logic wr_up;
    logic wr_down;
    logic wr_val;
    logic fin;
  } pls_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic             err;
    logic             at_end;
    logic             idx_at_pos;
    logic             idx1_lt_cnt;
    logic             idx2_lt_cnt;
  } pls_stat_t;

endpackage

`default_nettype wire

// ===== hdl/positional_list_store.sv =====
// positional_list_store: top level, controller plus datapath.
// Depends on pls_pkg, pls_ctrl, pls_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays
// high until the result is shown. Each request gives one result word on
// data_out/count/status, valid for the single cycle that done is high; the
// receiver cannot stall it, and a new request may be taken in that cycle.
// Entries live in a store with one read port and one write port. Error or
// reserved: check, finish. Read: check, read, capture, finish. Remove adds
// a read and write per entry above pos, insert per entry from pos up plus a
// value write. No clearing pass after reset.

`include "assert_macros.svh"

module positional_list_store import pls_pkg::*; #(
  parameter  int CAPACITY = 64,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] data_out,
  output logic [CW-1:0]            count,
  output logic [ST_W-1:0]          status
);

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pls_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_type (req_type),
    .position (position),
    .value    (value),
    .stat     (stat),
    .done     (done),
    .data_out (data_out),
    .count    (count),
    .status   (status)
  );

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `ASSERT_IMPL(a_count_cap, done, count <= CW'(CAPACITY), "count above capacity")
  `ASSERT_IMPL(a_err_zero, done && status != ST_OK, data_out == '0, "nonzero data on error")
  `ASSERT_NEXT(a_done_single, done, !done, "done held two cycles")

endmodule

`default_nettype wire

// ===== hdl/pls_ctrl.sv =====
// pls_ctrl: request sequencer for the positional list store.
// Depends on pls_pkg; drives pls_datapath through pls_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl import pls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pls_stat_t stat,
  output logic      busy,
  output pls_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_CAP, S_REM_RD, S_REM_WR,
    S_INS_RD, S_INS_WR, S_INS_VAL, S_FIN
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err) begin
          state_next = S_FIN;
        end else begin
          case (stat.kind)
            REQ_READ, REQ_REMOVE: begin
              cmd.idx_pos = 1'b1;
              state_next  = S_RD;
            end
            REQ_INSERT: begin
              if (stat.at_end) begin
                state_next = S_INS_VAL;
              end else begin
                cmd.idx_last = 1'b1;
                state_next   = S_INS_RD;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap = 1'b1;
        if (stat.kind == REQ_REMOVE && stat.idx1_lt_cnt) begin
          state_next = S_REM_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_REM_RD: begin
        cmd.rd      = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.wr_down = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = stat.idx2_lt_cnt ? S_REM_RD : S_FIN;
      end
      S_INS_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_up = 1'b1;
        if (stat.idx_at_pos) begin
          state_next = S_INS_VAL;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_INS_RD;
        end
      end
      S_INS_VAL: begin
        cmd.wr_val = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pls_datapath.sv =====
// pls_datapath: entry store, count, request registers, shift index and
// result registers. Depends on pls_pkg; sequenced by pls_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module pls_datapath import pls_pkg::*; #(
  parameter  int CAPACITY = 64,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pls_cmd_t                 cmd,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output pls_stat_t                stat,
  output logic                     done,
  output logic signed [DATA_W-1:0] data_out,
  output logic [CW-1:0]            count,
  output logic [ST_W-1:0]          status
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = ((CW + 1) > POS_W) ? (CW + 1) : POS_W;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [REQ_W-1:0]  kind;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     idx;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] dreg;
  logic [ST_W-1:0]   st;

  logic [CMPW-1:0]   pos_x, cnt_x, idx_x, idx1_x, idx2_x;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic              mem_we;

  assign pos_x  = CMPW'(pos);
  assign cnt_x  = CMPW'(cnt);
  assign idx_x  = CMPW'(idx);
  assign idx1_x = idx_x + CMPW'(1);
  assign idx2_x = idx_x + CMPW'(2);

  always_comb begin
    st = ST_OK;
    case (kind)
      REQ_READ, REQ_REMOVE: begin
        if (pos_x >= cnt_x) st = ST_RANGE;
      end
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_RANGE;
        end else if (cnt_x >= CMPW'(CAPACITY)) begin
          st = ST_FULL;
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (st == ST_OK) begin
      case (kind)
        REQ_INSERT: cnt_next = cnt + CW'(1);
        REQ_REMOVE: cnt_next = cnt - CW'(1);
        default:    cnt_next = cnt;
      endcase
    end
  end

  assign stat.kind        = kind;
  assign stat.err         = (st != ST_OK);
  assign stat.at_end      = (pos_x == cnt_x);
  assign stat.idx_at_pos  = (idx_x == pos_x);
  assign stat.idx1_lt_cnt = (idx1_x < cnt_x);
  assign stat.idx2_lt_cnt = (idx2_x < cnt_x);

  assign raddr  = cmd.rd_next ? (idx + AW'(1)) : idx;
  assign mem_we = cmd.wr_up | cmd.wr_down | cmd.wr_val;
  assign wdata  = cmd.wr_val ? val : rdata;

  always_comb begin
    waddr = idx;
    if (cmd.wr_val) begin
      waddr = AW'(pos);
    end else if (cmd.wr_up) begin
      waddr = idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.rd) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_type;
      pos  <= position;
      val  <= $unsigned(value);
      dreg <= '0;
    end else if (cmd.cap) begin
      dreg <= rdata;
    end
    if (cmd.idx_pos) begin
      idx <= AW'(pos);
    end else if (cmd.idx_last) begin
      idx <= AW'(cnt - CW'(1));
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end
    if (cmd.fin) begin
      data_out <= $signed(dreg);
      count    <= cnt_next;
      status   <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.fin) cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire
